### rtl/xalu_pkg.sv
// Shared types, constants and helper functions for the x86 integer ALU with flags.
package xalu_pkg;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_SBB   = 3'd2,
    MODE_INC   = 3'd3,
    MODE_DEC   = 3'd4,
    MODE_SEXT  = 3'd5,
    MODE_ZEXT  = 3'd6,
    MODE_SFILL = 3'd7
  } mode_t;

  localparam logic [2:0] SIZE_BYTE  = 3'd1;
  localparam logic [2:0] SIZE_WORD  = 3'd2;
  localparam logic [2:0] SIZE_DWORD = 3'd4;

  // EFLAGS bit positions.
  localparam int unsigned FL_CF = 0;
  localparam int unsigned FL_PF = 2;
  localparam int unsigned FL_AF = 4;
  localparam int unsigned FL_ZF = 6;
  localparam int unsigned FL_SF = 7;
  localparam int unsigned FL_OF = 11;

  localparam logic [31:0] UPD_ALL   = 32'h0000_08D5;
  localparam logic [31:0] UPD_NO_CF = 32'h0000_08D4;

  // Decoded operation, held between the decode and adder stages.
  typedef struct packed {
    logic        err;
    mode_t       mode;
    logic [31:0] a;
    logic [31:0] b;
    logic        cin;
    logic [31:0] mask;
    logic [31:0] sign;
    logic [31:0] ext_res;
    logic [31:0] flags;
  } dec_t;

  // Adder output, held between the adder and flag stages.
  typedef struct packed {
    logic        err;
    mode_t       mode;
    logic [31:0] a;
    logic [31:0] b;
    logic [33:0] wide;
    logic [31:0] mask;
    logic [31:0] sign;
    logic [31:0] ext_res;
    logic [31:0] flags;
  } sum_t;

  function automatic logic size_ok(input logic [2:0] s);
    return (s inside {SIZE_BYTE, SIZE_WORD, SIZE_DWORD});
  endfunction

  function automatic logic [31:0] size_mask(input logic [2:0] s);
    logic [31:0] m;
    case (s)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_WORD: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] size_sign(input logic [2:0] s);
    logic [31:0] sb;
    case (s)
      SIZE_BYTE: sb = 32'h0000_0080;
      SIZE_WORD: sb = 32'h0000_8000;
      default:   sb = 32'h8000_0000;
    endcase
    return sb;
  endfunction

endpackage

### rtl/x86_integer_alu_flags.sv
// Top level of the three-stage x86 integer ALU with EFLAGS derivation.
//
// Usage: one operation enters on the input channel (in_valid/in_ready) with
// its mode, operand sizes, destination and source values and the incoming
// EFLAGS word. Exactly one result beat leaves on the output channel
// (out_valid/out_ready) carrying the masked result, the updated EFLAGS and a
// size error bit. Results leave in the order the operations came in.
// An accepted input beat passes the decode, adder and result registers in
// turn. Throughput is one beat per cycle when the receiver does not stall:
// the three stages are decode and operand extension, the 34-bit
// add/subtract, and flag derivation with the result register.
// Each stage carries its own valid bit and advances whenever the stage ahead
// is empty or moving, so when the receiver holds out_ready low the pipeline
// fills up to three beats and then drops in_ready; nothing is lost or
// repeated. The synchronous active-low reset empties all stages; the
// payload registers are not cleared.
module x86_integer_alu_flags (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_mode,
  input  logic [2:0]           in_op_size,
  input  logic [31:0]          in_dest_value,
  input  logic [31:0]          in_src_value,
  input  logic [2:0]           in_src_size,
  input  logic [31:0]          in_flags_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_result_value,
  output logic [31:0]          out_flags_out,
  output logic                 out_size_error
);
  import xalu_pkg::*;

  // Stage valid bits and payload registers.
  logic        v1_r, v2_r, v3_r;
  dec_t        s1_r, s1_nxt;
  sum_t        s2_r, s2_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] flg_r, flg_nxt;
  logic        err_r, err_nxt;

  logic adv1, adv2, adv3;

  // A stage may load when it is empty or its content moves on this cycle.
  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // Stage 1: size checks, operand masking and source extension.
  mode_t       mode_in;
  logic        uses_src;
  logic [31:0] m_op, sb_op, m_src, sb_src, a_in, src_m, b_sext;

  always_comb begin
    mode_in  = mode_t'(in_mode);
    uses_src = (mode_in == MODE_ADD) || (mode_in == MODE_SUB) || (mode_in == MODE_SBB) ||
               (mode_in == MODE_SEXT) || (mode_in == MODE_ZEXT);
    m_op     = size_mask(in_op_size);
    sb_op    = size_sign(in_op_size);
    m_src    = size_mask(in_src_size);
    sb_src   = size_sign(in_src_size);
    a_in     = in_dest_value & m_op;
    src_m    = in_src_value & m_src;
    b_sext   = ((src_m & sb_src) != 32'd0) ? ((src_m | ~m_src) & m_op) : (src_m & m_op);

    s1_nxt.err   = !size_ok(in_op_size) ||
                   (uses_src && (!size_ok(in_src_size) || (in_src_size > in_op_size)));
    s1_nxt.mode  = mode_in;
    s1_nxt.a     = a_in;
    s1_nxt.b     = ((mode_in == MODE_INC) || (mode_in == MODE_DEC)) ? 32'd1 : b_sext;
    s1_nxt.cin   = (mode_in == MODE_SBB) ? in_flags_in[FL_CF] : 1'b0;
    s1_nxt.mask  = m_op;
    s1_nxt.sign  = sb_op;
    s1_nxt.flags = in_flags_in;
    case (mode_in)
      MODE_SEXT:  s1_nxt.ext_res = b_sext;
      MODE_ZEXT:  s1_nxt.ext_res = src_m;
      default:    s1_nxt.ext_res = ((a_in & sb_op) != 32'd0) ? m_op : 32'd0;
    endcase
  end

  // Stage 2: 34-bit addition, or subtraction with borrow, selected by the mode.
  logic is_sub1;

  always_comb begin
    is_sub1 = (s1_r.mode == MODE_SUB) || (s1_r.mode == MODE_SBB) || (s1_r.mode == MODE_DEC);
    s2_nxt.err     = s1_r.err;
    s2_nxt.mode    = s1_r.mode;
    s2_nxt.a       = s1_r.a;
    s2_nxt.b       = s1_r.b;
    s2_nxt.mask    = s1_r.mask;
    s2_nxt.sign    = s1_r.sign;
    s2_nxt.ext_res = s1_r.ext_res;
    s2_nxt.flags   = s1_r.flags;
    if (is_sub1) begin
      s2_nxt.wide = {2'b00, s1_r.a} - {2'b00, s1_r.b} - {33'd0, s1_r.cin};
    end else begin
      s2_nxt.wide = {2'b00, s1_r.a} + {2'b00, s1_r.b};
    end
  end

  // Stage 3: flag derivation and merge into the outgoing EFLAGS word.
  logic        is_sub2, is_arith, carry;
  logic [31:0] res_ar, f, upd;

  always_comb begin
    is_sub2  = (s2_r.mode == MODE_SUB) || (s2_r.mode == MODE_SBB) || (s2_r.mode == MODE_DEC);
    is_arith = (s2_r.mode == MODE_ADD) || (s2_r.mode == MODE_INC) || is_sub2;
    res_ar   = s2_r.wide[31:0] & s2_r.mask;
    // A negative difference means a borrow; an add carries past the operand size.
    carry    = is_sub2 ? s2_r.wide[33] : (s2_r.wide[32:0] > {1'b0, s2_r.mask});

    f        = 32'd0;
    f[FL_CF] = carry;
    f[FL_PF] = ~(^res_ar[7:0]);
    f[FL_AF] = s2_r.a[4] ^ s2_r.b[4] ^ res_ar[4];
    f[FL_ZF] = (res_ar == 32'd0);
    f[FL_SF] = ((res_ar & s2_r.sign) != 32'd0);
    if (is_sub2) begin
      f[FL_OF] = (((s2_r.a ^ s2_r.b) & (s2_r.a ^ res_ar) & s2_r.sign) != 32'd0);
    end else begin
      f[FL_OF] = (((s2_r.a ^ res_ar) & (s2_r.b ^ res_ar) & s2_r.sign) != 32'd0);
    end

    // Inc and dec leave the carry flag alone.
    upd = ((s2_r.mode == MODE_INC) || (s2_r.mode == MODE_DEC)) ? UPD_NO_CF : UPD_ALL;

    err_nxt = s2_r.err;
    if (s2_r.err) begin
      res_nxt = 32'd0;
      flg_nxt = s2_r.flags;
    end else if (is_arith) begin
      res_nxt = res_ar;
      flg_nxt = (s2_r.flags & ~upd) | (f & upd);
    end else begin
      res_nxt = s2_r.ext_res;
      flg_nxt = s2_r.flags;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) s1_r <= s1_nxt;
    if (adv2 && v1_r)     s2_r <= s2_nxt;
    if (adv3 && v2_r) begin
      res_r <= res_nxt;
      flg_r <= flg_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_valid        = v3_r;
  assign out_result_value = res_r;
  assign out_flags_out    = flg_r;
  assign out_size_error   = err_r;

endmodule

### rtl/xalu_checker.sv
// Port-level assertions for the x86 integer ALU, bound to the top level.
module xalu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic [31:0] out_flags_out,
  input logic        out_size_error
);

  // A stalled result beat stays put with its payload unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) &&
      $stable(out_flags_out) && $stable(out_size_error))
    else $error("stalled result beat changed");

  // A size error always reports a zero result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_size_error |-> out_result_value == 32'd0)
    else $error("size error with nonzero result");

  // With the output stage empty the whole pipeline can move, so input is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused while output stage empty");

  // Reset empties the pipeline.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat present right after reset");

endmodule

bind x86_integer_alu_flags xalu_checker u_xalu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value),
  .out_flags_out    (out_flags_out),
  .out_size_error   (out_size_error)
);
